@@ rtl/grm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

   // input item kinds, carried on req_tuser
   localparam logic KIND_MAP_WRITE = 1'b0;
   localparam logic KIND_RAY       = 1'b1;

   // map cell codes
   localparam logic [1:0] CELL_EMPTY  = 2'd0;
   localparam logic [1:0] CELL_SOLID  = 2'd1;
   localparam logic [1:0] CELL_MIRROR = 2'd2;

   // segment end causes
   localparam logic [2:0] CAUSE_BOUNCE       = 3'd0;
   localparam logic [2:0] CAUSE_SOLID        = 3'd1;
   localparam logic [2:0] CAUSE_MIRROR_LIMIT = 3'd2;
   localparam logic [2:0] CAUSE_LEFT_MAP     = 3'd3;
   localparam logic [2:0] CAUSE_STEP_CAP     = 3'd4;

   // fixed field widths
   localparam int COORD_W = 16;
   localparam int STEP_W  = 14;
   localparam int END_W   = 18;

   // most negative step, negated it saturates
   localparam logic signed [STEP_W-1:0] STEP_MOST_NEG = 14'sh2000;
   localparam logic signed [STEP_W-1:0] STEP_MOST_POS = 14'sh1FFF;

   // control from the marcher to the map memory
   typedef struct packed {
      logic       wr_en;
      logic [1:0] wr_cell;
      logic       rd_en;
   } map_req_type;

endpackage

`default_nettype wire

@@ rtl/grm_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

module grm_map #(
   parameter int AW = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire grm_pkg::map_req_type map_req,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [AW-1:0]        rd_addr,
   output logic [1:0]                rd_cell,
   output logic                      clr_busy
);
   import grm_pkg::*;

   logic [1:0]    mem [2**AW];
   logic [1:0]    rd_cell_ff;
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [1:0]    mem_wdata;

   // clearing sweep owns the write port after reset
   always_comb begin
      mem_we    = clr_busy_ff | map_req.wr_en;
      mem_waddr = clr_busy_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clr_busy_ff ? CELL_EMPTY : map_req.wr_cell;
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {AW{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (map_req.rd_en) begin
         rd_cell_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign rd_cell  = rd_cell_ff;
   assign clr_busy = clr_busy_ff;

endmodule

`default_nettype wire

@@ rtl/grm_march.sv @@
`timescale 1ns / 1ps
`default_nettype none

module grm_march #(
   parameter int MAP_SIDE    = 16,
   parameter int FRAC_BITS   = 12,
   parameter int MAX_BOUNCES = 3,
   parameter int MAX_STEPS   = 1024,
   parameter int AW          = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input item
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 kind,
   input  wire logic [3:0]           cell_x,
   input  wire logic [3:0]           cell_y,
   input  wire logic [1:0]           cell_value,
   input  wire logic [15:0]          start_x,
   input  wire logic [15:0]          start_y,
   input  wire logic signed [13:0]   step_x,
   input  wire logic signed [13:0]   step_y,
   // map memory
   output grm_pkg::map_req_type      map_req,
   output logic [AW-1:0]             map_wr_addr,
   output logic [AW-1:0]             map_rd_addr,
   input  wire logic [1:0]           map_rd_cell,
   input  wire logic                 clr_busy,
   // result segment
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [15:0]               seg_start_x,
   output logic [15:0]               seg_start_y,
   output logic [17:0]               seg_end_x,
   output logic [17:0]               seg_end_y,
   output logic [1:0]                bounces,
   output logic [2:0]                end_cause,
   output logic                      last
);
   import grm_pkg::*;

   localparam int CW    = AW / 2;
   localparam int CIW   = (CW > 4) ? CW : 4;
   localparam int LIM   = MAP_SIDE << FRAC_BITS;
   localparam int LIM_W = (LIM > 65536) ? $clog2(LIM) : 16;
   localparam int POS_W = LIM_W + 2;
   localparam int SC_W  = $clog2(MAX_STEPS + 1);

   localparam logic [POS_W-1:0] LIM_V     = POS_W'(LIM);
   localparam logic [SC_W-1:0]  STEP_CAP  = SC_W'(MAX_STEPS);
   localparam logic [1:0]       BOUNCE_CAP = 2'(MAX_BOUNCES);
   localparam logic [6:0]       SIDE_V    = 7'(MAP_SIDE);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_ADV   = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic                     first_ff, first_in;
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [13:0]       dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [1:0]               bounce_ff, bounce_in;
   logic [SC_W-1:0]          steps_ff, steps_in;
   logic [15:0]              org_x_ff, org_x_in, org_y_ff, org_y_in;

   logic                     out_valid_ff;
   logic [15:0]              out_sx_ff, out_sy_ff;
   logic [17:0]              out_ex_ff, out_ey_ff;
   logic [1:0]               out_b_ff;
   logic [2:0]               out_cause_ff;
   logic                     out_last_ff;

   logic                     out_load;
   logic [2:0]               out_cause;
   logic                     out_last;
   logic [POS_W-1:0]         out_ex, out_ey;

   logic                     out_free;
   logic                     accept;
   logic signed [POS_W-1:0]  next_x, next_y;
   logic                     next_in_map, pos_in_map, start_in_map;
   logic [POS_W-1:0]         sx_ext, sy_ext;
   logic [CIW-1:0]           cx_ext, cy_ext;
   logic                     cell_in_range;

   function automatic logic in_map(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
      in_map = !x[POS_W-1] && !y[POS_W-1] && (x < LIM_V) && (y < LIM_V);
   endfunction

   always_comb begin
      next_x = pos_x_ff + {{(POS_W-14){dir_x_ff[13]}}, dir_x_ff};
      next_y = pos_y_ff + {{(POS_W-14){dir_y_ff[13]}}, dir_y_ff};
      next_in_map  = in_map(next_x, next_y);
      pos_in_map   = in_map(pos_x_ff, pos_y_ff);
      sx_ext       = POS_W'(start_x);
      sy_ext       = POS_W'(start_y);
      start_in_map = in_map(sx_ext, sy_ext);
      cx_ext       = CIW'(cell_x);
      cy_ext       = CIW'(cell_y);
      cell_in_range = ({3'b000, cell_x} < SIDE_V) && ({3'b000, cell_y} < SIDE_V);
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !clr_busy;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      bounce_in = bounce_ff;
      steps_in  = steps_ff;
      org_x_in  = org_x_ff;
      org_y_in  = org_y_ff;

      map_req     = '0;
      map_wr_addr = {cy_ext[CW-1:0], cx_ext[CW-1:0]};
      map_rd_addr = {next_y[FRAC_BITS +: CW], next_x[FRAC_BITS +: CW]};

      out_load  = 1'b0;
      out_cause = CAUSE_SOLID;
      out_last  = 1'b1;
      out_ex    = pos_x_ff;
      out_ey    = pos_y_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (kind == KIND_MAP_WRITE) begin
                  map_req.wr_en   = cell_in_range;
                  map_req.wr_cell = cell_value;
               end else begin
                  pos_x_in  = sx_ext;
                  pos_y_in  = sy_ext;
                  dir_x_in  = step_x;
                  dir_y_in  = step_y;
                  bounce_in = '0;
                  steps_in  = '0;
                  org_x_in  = start_x;
                  org_y_in  = start_y;
                  if (start_in_map) begin
                     map_req.rd_en = 1'b1;
                     map_rd_addr   = {sy_ext[FRAC_BITS +: CW], sx_ext[FRAC_BITS +: CW]};
                     first_in      = 1'b1;
                     state_in      = S_CHECK;
                  end
               end
            end
         end
         S_CHECK, S_ADV: begin
            if (state_ff == S_CHECK && first_ff && map_rd_cell != CELL_EMPTY) begin
               // ray born inside a non-empty cell: nothing to report
               state_in = S_IDLE;
            end else if (state_ff == S_CHECK && map_rd_cell != CELL_EMPTY &&
                         map_rd_cell != CELL_MIRROR) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  out_cause = CAUSE_SOLID;
                  state_in  = S_IDLE;
               end
            end else if (state_ff == S_CHECK && map_rd_cell == CELL_MIRROR &&
                         bounce_ff >= BOUNCE_CAP) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  out_cause = CAUSE_MIRROR_LIMIT;
                  state_in  = S_IDLE;
               end
            end else if (state_ff == S_CHECK && steps_ff >= STEP_CAP) begin
               if (out_free) begin
                  out_load  = 1'b1;
                  out_cause = CAUSE_STEP_CAP;
                  state_in  = S_IDLE;
               end
            end else if (state_ff == S_CHECK && map_rd_cell == CELL_MIRROR) begin
               // close the segment, flip x, take the step in S_ADV
               if (out_free) begin
                  out_load  = 1'b1;
                  out_cause = CAUSE_BOUNCE;
                  out_last  = 1'b0;
                  bounce_in = bounce_ff + 1'b1;
                  org_x_in  = pos_x_ff[15:0];
                  org_y_in  = pos_y_ff[15:0];
                  dir_x_in  = (dir_x_ff == STEP_MOST_NEG) ? STEP_MOST_POS : -dir_x_ff;
                  first_in  = 1'b0;
                  state_in  = S_ADV;
               end
            end else if (next_in_map) begin
               pos_x_in      = next_x;
               pos_y_in      = next_y;
               steps_in      = steps_ff + 1'b1;
               map_req.rd_en = 1'b1;
               first_in      = 1'b0;
               state_in      = S_CHECK;
            end else if (out_free) begin
               pos_x_in  = next_x;
               pos_y_in  = next_y;
               steps_in  = steps_ff + 1'b1;
               out_load  = 1'b1;
               out_cause = CAUSE_LEFT_MAP;
               out_ex    = next_x;
               out_ey    = next_y;
               first_in  = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      dir_x_ff  <= dir_x_in;
      dir_y_ff  <= dir_y_in;
      bounce_ff <= bounce_in;
      steps_ff  <= steps_in;
      org_x_ff  <= org_x_in;
      org_y_ff  <= org_y_in;
      if (out_load) begin
         out_sx_ff    <= org_x_ff;
         out_sy_ff    <= org_y_ff;
         out_ex_ff    <= out_ex[17:0];
         out_ey_ff    <= out_ey[17:0];
         out_b_ff     <= bounce_ff;
         out_cause_ff <= out_cause;
         out_last_ff  <= out_last;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign seg_start_x = out_sx_ff;
   assign seg_start_y = out_sy_ff;
   assign seg_end_x   = out_ex_ff;
   assign seg_end_y   = out_ey_ff;
   assign bounces     = out_b_ff;
   assign end_cause   = out_cause_ff;
   assign last        = out_last_ff;

   a_no_march_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !clr_busy)
      else $error("ray marching while map clear sweep runs");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("segment loaded over an untaken segment");

   a_step_count_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (steps_ff <= STEP_CAP))
      else $error("step counter ran past the cap");

   a_check_inside_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> pos_in_map)
      else $error("cell check for a point outside the map");

   a_read_then_check: assert property (@(posedge clock) disable iff (reset)
      map_req.rd_en |=> (state_ff == S_CHECK))
      else $error("map read data not consumed by a check");

endmodule

`default_nettype wire

@@ rtl/grid_ray_march_reflect.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  tdata / tuser / tlast
// req_     in   tdata: cell_x, cell_y, cell_value, start_x, start_y, step_x, step_y
//               tuser: kind (0 map write, 1 ray)
// rsp_     out  tdata: seg_start_x, seg_start_y, seg_end_x, seg_end_y, bounces, end_cause
//               tlast: last segment of the ray
//
// a map write lands at the edge that takes it and a new item can follow; a ray first
// reads its start cell, then marches one step per cycle (one map read each, one
// synchronous read port) plus an S_ADV state per mirror hit, stretched while rsp_
// holds a segment; after reset a sweep clears all 2**(2*clog2(MAP_SIDE)) map cells,
// one cell a cycle, and req_tready stays low during that sweep and while a ray marches
module grid_ray_march_reflect #(
   parameter int MAP_SIDE    = 16,
   parameter int FRAC_BITS   = 12,
   parameter int MAX_BOUNCES = 3,
   parameter int MAX_STEPS   = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cell_x[3:0] cell_y[7:4] cell_value[9:8] start_x[25:10] start_y[41:26]
   // step_x[55:42] step_y[69:56], zero fill [71:70]
   input  wire logic [71:0] req_tdata,
   // kind
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // seg_start_x[15:0] seg_start_y[31:16] seg_end_x[49:32] seg_end_y[67:50]
   // bounces[69:68] end_cause[72:70], zero fill [79:73]
   output logic [79:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import grm_pkg::*;

   localparam int CW = $clog2(MAP_SIDE);
   localparam int AW = 2 * CW;

   map_req_type   map_req;
   logic [AW-1:0] map_wr_addr, map_rd_addr;
   logic [1:0]    map_rd_cell;
   logic          clr_busy;

   logic [15:0]   seg_start_x, seg_start_y;
   logic [17:0]   seg_end_x, seg_end_y;
   logic [1:0]    bounces;
   logic [2:0]    end_cause;

   grm_map #(
      .AW(AW)
   ) u_map (
      .clock    (clock),
      .reset    (reset),
      .map_req  (map_req),
      .wr_addr  (map_wr_addr),
      .rd_addr  (map_rd_addr),
      .rd_cell  (map_rd_cell),
      .clr_busy (clr_busy)
   );

   grm_march #(
      .MAP_SIDE    (MAP_SIDE),
      .FRAC_BITS   (FRAC_BITS),
      .MAX_BOUNCES (MAX_BOUNCES),
      .MAX_STEPS   (MAX_STEPS),
      .AW          (AW)
   ) u_march (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .kind        (req_tuser),
      .cell_x      (req_tdata[3:0]),
      .cell_y      (req_tdata[7:4]),
      .cell_value  (req_tdata[9:8]),
      .start_x     (req_tdata[25:10]),
      .start_y     (req_tdata[41:26]),
      .step_x      (req_tdata[55:42]),
      .step_y      (req_tdata[69:56]),
      .map_req     (map_req),
      .map_wr_addr (map_wr_addr),
      .map_rd_addr (map_rd_addr),
      .map_rd_cell (map_rd_cell),
      .clr_busy    (clr_busy),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .seg_start_x (seg_start_x),
      .seg_start_y (seg_start_y),
      .seg_end_x   (seg_end_x),
      .seg_end_y   (seg_end_y),
      .bounces     (bounces),
      .end_cause   (end_cause),
      .last        (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, end_cause, bounces, seg_end_y, seg_end_x, seg_start_y, seg_start_x};

endmodule

`default_nettype wire

@@ tb/sv/grid_ray_march_reflect_checker.sv @@
`timescale 1ns / 1ps

module grid_ray_march_reflect_checker #(
   parameter int MAP_SIDE    = 16,
   parameter int FRAC_BITS   = 12,
   parameter int MAX_BOUNCES = 3,
   parameter int MAX_STEPS   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          errors,
   output int          pending,
   output int          seg_count,
   output logic [4:0]  causes_seen
);
   import grm_pkg::*;

   typedef struct packed {
      logic [15:0] sx;
      logic [15:0] sy;
      logic [17:0] ex;
      logic [17:0] ey;
      logic [1:0]  bounces;
      logic [2:0]  cause;
      logic        last;
   } segment_type;

   localparam int MAP_LIMIT = MAP_SIDE << FRAC_BITS;

   logic [1:0]  cell_map [MAP_SIDE*MAP_SIDE];
   segment_type seg_queue [$];
   segment_type want;
   int          fail_cnt   = 0;
   int          seg_total  = 0;
   logic [4:0]  cause_mask = '0;

   function automatic bit on_map(logic signed [17:0] x, logic signed [17:0] y);
      return x >= 0 && y >= 0 && x < MAP_LIMIT && y < MAP_LIMIT;
   endfunction

   // only called for points on the map
   function automatic logic [1:0] cell_at(logic signed [17:0] x, logic signed [17:0] y);
      return cell_map[int'(y >>> FRAC_BITS) * MAP_SIDE + int'(x >>> FRAC_BITS)];
   endfunction

   task automatic emit_segment(input logic [15:0] ox, input logic [15:0] oy,
                               input logic signed [17:0] px, input logic signed [17:0] py,
                               input logic [1:0] nb, input logic [2:0] cause,
                               input logic last);
      segment_type s;
      s.sx      = ox;
      s.sy      = oy;
      s.ex      = px;
      s.ey      = py;
      s.bounces = nb;
      s.cause   = cause;
      s.last    = last;
      seg_queue.push_back(s);
   endtask

   // marches one ray over the shadow map and queues its segments
   task automatic trace_ray(input logic [15:0] sx, input logic [15:0] sy,
                            input logic signed [13:0] dx_in,
                            input logic signed [13:0] dy_in);
      logic signed [17:0] px;
      logic signed [17:0] py;
      logic signed [13:0] dx;
      logic signed [13:0] dy;
      logic [15:0]        ox;
      logic [15:0]        oy;
      logic [1:0]         c;
      int                 nb;
      int                 steps;
      bit                 run;
      px = {2'b00, sx};
      py = {2'b00, sy};
      dx = dx_in;
      dy = dy_in;
      ox = sx;
      oy = sy;
      nb = 0;
      steps = 0;
      run = 1'b1;
      if (!on_map(px, py) || cell_at(px, py) != CELL_EMPTY)
         run = 1'b0;
      while (run) begin
         c = cell_at(px, py);
         if (c != CELL_EMPTY && c != CELL_MIRROR) begin
            emit_segment(ox, oy, px, py, 2'(nb), CAUSE_SOLID, 1'b1);
            run = 1'b0;
         end else if (c == CELL_MIRROR && nb >= MAX_BOUNCES) begin
            emit_segment(ox, oy, px, py, 2'(nb), CAUSE_MIRROR_LIMIT, 1'b1);
            run = 1'b0;
         end else if (steps >= MAX_STEPS) begin
            emit_segment(ox, oy, px, py, 2'(nb), CAUSE_STEP_CAP, 1'b1);
            run = 1'b0;
         end else begin
            if (c == CELL_MIRROR) begin
               emit_segment(ox, oy, px, py, 2'(nb), CAUSE_BOUNCE, 1'b0);
               nb++;
               ox = px[15:0];
               oy = py[15:0];
               // reflect: x step flips sign, most negative saturates
               if (dx == STEP_MOST_NEG)
                  dx = STEP_MOST_POS;
               else
                  dx = -dx;
            end
            px = px + dx;
            py = py + dy;
            steps++;
            if (!on_map(px, py)) begin
               emit_segment(ox, oy, px, py, 2'(nb), CAUSE_LEFT_MAP, 1'b1);
               run = 1'b0;
            end
         end
      end
   endtask

   task automatic compare_field(input string what, input logic [17:0] exp_val,
                                input logic [17:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val,
                  act_val);
         fail_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (cell_map[i]) cell_map[i] = CELL_EMPTY;
         seg_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_MAP_WRITE) begin
               if (req_tdata[3:0] < MAP_SIDE && req_tdata[7:4] < MAP_SIDE)
                  cell_map[req_tdata[7:4] * MAP_SIDE + req_tdata[3:0]] = req_tdata[9:8];
            end else begin
               trace_ray(req_tdata[25:10], req_tdata[41:26], req_tdata[55:42],
                         req_tdata[69:56]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (seg_queue.size() == 0) begin
               $display("%0t: unexpected segment beat, expected none, actual %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               fail_cnt++;
            end else begin
               want = seg_queue.pop_front();
               compare_field("seg_start_x", 18'(want.sx), 18'(rsp_tdata[15:0]));
               compare_field("seg_start_y", 18'(want.sy), 18'(rsp_tdata[31:16]));
               compare_field("seg_end_x", want.ex, rsp_tdata[49:32]);
               compare_field("seg_end_y", want.ey, rsp_tdata[67:50]);
               compare_field("bounces", 18'(want.bounces), 18'(rsp_tdata[69:68]));
               compare_field("end_cause", 18'(want.cause), 18'(rsp_tdata[72:70]));
               compare_field("last", 18'(want.last), 18'(rsp_tlast));
               seg_total++;
               cause_mask[want.cause] = 1'b1;
            end
         end
      end
      errors      <= fail_cnt;
      pending     <= seg_queue.size();
      seg_count   <= seg_total;
      causes_seen <= cause_mask;
   end

endmodule

@@ tb/sv/grid_ray_march_reflect_tb.sv @@
`timescale 1ns / 1ps

module grid_ray_march_reflect_tb;
   import grm_pkg::*;

   localparam int MAP_SIDE    = 16;
   localparam int FRAC_BITS   = 12;
   localparam int MAX_BOUNCES = 3;
   localparam int MAX_STEPS   = 1024;

   localparam logic [1:0] CELL_SOLID_ALT = 2'd3;
   localparam int         TAIL_CYCLES    = MAX_STEPS + MAX_BOUNCES + 16;
   localparam int         CYCLE_LIMIT    = 2_000_000;
   localparam int         PHASES         = 6;
   localparam int         PHASE_ITEMS    = 55;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        req_tuser  = KIND_MAP_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;

   int         errors;
   int         pending;
   int         seg_count;
   logic [4:0] causes_seen;

   bit no_idle    = 1'b0;
   bit draining   = 1'b0;
   int ready_hold = 0;
   int gap_len;
   int cycles     = 0;
   int n_writes   = 0;
   int n_rays     = 0;

   grid_ray_march_reflect #(
      .MAP_SIDE(MAP_SIDE), .FRAC_BITS(FRAC_BITS),
      .MAX_BOUNCES(MAX_BOUNCES), .MAX_STEPS(MAX_STEPS)
   ) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   grid_ray_march_reflect_checker #(
      .MAP_SIDE(MAP_SIDE), .FRAC_BITS(FRAC_BITS),
      .MAX_BOUNCES(MAX_BOUNCES), .MAX_STEPS(MAX_STEPS)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .errors(errors), .pending(pending),
      .seg_count(seg_count), .causes_seen(causes_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d segments outstanding", cycles, pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle)
         return 0;
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (draining) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_tready) begin
         gap_len = pick_gap();
         if (gap_len > 0) begin
            rsp_tready <= 1'b0;
            ready_hold <= gap_len - 1;
         end else begin
            ready_hold <= $urandom_range(0, 8);
         end
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 8);
      end
   end

   function automatic logic [71:0] pack_req(logic [3:0] cx, logic [3:0] cy, logic [1:0] v,
                                            logic [15:0] sx, logic [15:0] sy,
                                            logic [13:0] dx, logic [13:0] dy);
      return {2'b00, dy, dx, sy, sx, v, cy, cx};
   endfunction

   // called at the edge that took the previous beat
   task automatic send_beat(input logic kind, input logic [71:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_cell(input logic [3:0] cx, input logic [3:0] cy, input logic [1:0] v);
      send_beat(KIND_MAP_WRITE, pack_req(cx, cy, v, 16'($urandom()), 16'($urandom()),
                                         14'($urandom()), 14'($urandom())));
      n_writes++;
   endtask

   task automatic cast_ray(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [13:0] dx, input logic [13:0] dy);
      send_beat(KIND_RAY, pack_req(4'($urandom()), 4'($urandom()), 2'($urandom()),
                                   sx, sy, dx, dy));
      n_rays++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [13:0] signed_mag(int lo, int hi);
      int v;
      v = $urandom_range(lo, hi);
      if ($urandom_range(0, 1) == 1)
         v = -v;
      return 14'(v);
   endfunction

   task automatic random_cell();
      int r;
      logic [1:0] v;
      r = $urandom_range(0, 99);
      if (r < 50)
         v = CELL_EMPTY;
      else if (r < 70)
         v = CELL_SOLID;
      else if (r < 95)
         v = CELL_MIRROR;
      else
         v = CELL_SOLID_ALT;
      write_cell(4'($urandom()), 4'($urandom()), v);
   endtask

   task automatic random_ray();
      int r;
      logic [13:0] dx;
      logic [13:0] dy;
      logic [13:0] t;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         dx = signed_mag(300, 4096);
         dy = signed_mag(300, 4096);
      end else if (r < 85) begin
         dx = 14'($urandom());
         dy = 14'($urandom());
      end else if (r < 92) begin
         // slow rays, long marches toward the step cap
         dx = signed_mag(1, 40);
         dy = signed_mag(1, 40);
      end else if (r < 98) begin
         dx = '0;
         dy = signed_mag(300, 4096);
         if ($urandom_range(0, 1) == 1) begin
            t  = dx;
            dx = dy;
            dy = t;
         end
      end else begin
         dx = '0;
         dy = '0;
      end
      cast_ray(16'($urandom()), 16'($urandom()), dx, dy);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // mirrors facing each other on row 8, solids in the way elsewhere
      write_cell(4'd2, 4'd8, CELL_MIRROR);
      write_cell(4'd12, 4'd8, CELL_MIRROR);
      write_cell(4'd5, 4'd3, CELL_SOLID);
      write_cell(4'd15, 4'd15, CELL_SOLID_ALT);
      write_cell(4'd15, 4'd0, CELL_EMPTY);

      cast_ray(16'd30720, 16'd34816, 14'sd4096, 14'sd0);       // bounces until the limit
      cast_ray(16'd34816, 16'd34816, STEP_MOST_NEG, 14'sd0);   // saturating reflection
      cast_ray(16'd22528, 16'd2048, 14'sd0, 14'sd4096);        // runs into a solid
      cast_ray(16'd22528, 16'd14336, 14'sd4096, 14'sd0);       // starts inside a solid
      cast_ray(16'hFFFF, 16'hFFFF, 14'sd4096, 14'sd4096);      // starts in the alt solid
      cast_ray(16'd63488, 16'd2048, 14'sd0, 14'sd4096);        // walks into the alt solid
      cast_ray(16'd2048, 16'd2048, 14'sd0, 14'sd0);            // zero step hits the cap
      cast_ray(16'd0, 16'd0, -14'sd1, -14'sd1);                // leaves below zero
      cast_ray(16'hFFFF, 16'd0, 14'sd1, 14'sd0);               // leaves past the far edge
      cast_ray(16'd4096, 16'd4096, STEP_MOST_POS, STEP_MOST_POS);
      cast_ray(16'd43008, 16'd43008, -14'sd4096, 14'sd4096);
      cast_ray(16'd6144, 16'd43008, 14'sd1, -14'sd1);          // tiny step, step cap
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         no_idle = (p == 2 || p == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 30)
               random_cell();
            else
               random_ray();
         end
         wait_drained();
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      draining   <= 1'b1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d map writes and %0d rays, %0d segments checked", n_writes,
               n_rays, seg_count);
      $display("end causes seen (step cap..bounce) %b, %0d cycles", causes_seen, cycles);
      if (errors == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
